>>> rtl/address_region_table_top_defines.svh
// assertion macros for the address region table checker
// expects clk and rst_n in the scope of each use
`ifndef ADDRESS_REGION_TABLE_TOP_DEFINES_SVH
`define ADDRESS_REGION_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ART_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ART_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/art_pkg.sv
// shared types and constants for the address region table
// no dependencies
`default_nettype none

package art_pkg;

  localparam int REGION_COUNT = 16;
  localparam int ADDR_BITS    = 48;
  localparam int TAG_BITS     = 16;
  localparam int SLOT_BITS    = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [SLOT_BITS-1:0] slot_idx_t;
  typedef logic [1:0]           func_t;
  typedef logic [1:0]           status_t;

  // operation codes
  localparam func_t FN_LOOKUP = 2'd0;
  localparam func_t FN_INSERT = 2'd1;
  localparam func_t FN_DELETE = 2'd2;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERLAP  = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic    load;        // capture the accepted item, restart scan
    logic    step;        // advance to the next slot
    logic    note_free;   // current slot is free, remember it if first
    logic    wr_slot;     // store the insert range in the free slot
    logic    clr_slot;    // free the current slot
    logic    set_res;     // capture the result
    logic    res_hit;
    status_t res_status;
    logic    out_load;    // move the result into the output register
  } art_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  cur_valid;
    logic  contain;
    logic  overlap;
    logic  tag_eq;
    logic  last;
    logic  free_seen;
  } art_stat_t;

endpackage

`default_nettype wire

>>> rtl/art_ifs.sv
// valid/ready channel interfaces for the request and result sides
// depends on art_pkg
`default_nettype none

interface art_in_if;
  logic               valid;
  logic               ready;
  art_pkg::func_t     func;
  art_pkg::addr_t     lookup_addr;
  art_pkg::addr_t     range_start;
  art_pkg::addr_t     range_end;
  art_pkg::tag_t      region_tag;

  modport source (output valid, func, lookup_addr, range_start, range_end, region_tag,
                  input ready);
  modport sink   (input valid, func, lookup_addr, range_start, range_end, region_tag,
                  output ready);
endinterface

interface art_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  art_pkg::tag_t      hit_tag;
  art_pkg::status_t   status;

  modport source (output valid, hit, hit_tag, status, input ready);
  modport sink   (input valid, hit, hit_tag, status, output ready);
endinterface

`default_nettype wire

>>> rtl/art_ctrl.sv
// sequencer for the region table: accept, slot scan, result handoff
// depends on art_pkg
`default_nettype none

module art_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire art_pkg::art_stat_t stat,
  output art_pkg::art_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (stat.func)
          art_pkg::FN_LOOKUP: begin
            if (stat.cur_valid && stat.contain) begin
              cmd.set_res    = 1'b1;
              cmd.res_hit    = 1'b1;
              cmd.res_status = art_pkg::ST_OK;
              state_nxt      = S_RESP;
            end else if (stat.last) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = art_pkg::ST_NOTFOUND;
              state_nxt      = S_RESP;
            end else begin
              cmd.step = 1'b1;
            end
          end
          art_pkg::FN_INSERT: begin
            if (stat.cur_valid && stat.overlap) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = art_pkg::ST_OVERLAP;
              state_nxt      = S_RESP;
            end else if (stat.last) begin
              cmd.set_res = 1'b1;
              state_nxt   = S_RESP;
              // free slot may be the last one itself
              if (stat.free_seen || !stat.cur_valid) begin
                cmd.wr_slot    = 1'b1;
                cmd.res_status = art_pkg::ST_OK;
              end else begin
                cmd.res_status = art_pkg::ST_FULL;
              end
            end else begin
              cmd.step      = 1'b1;
              cmd.note_free = !stat.cur_valid;
            end
          end
          art_pkg::FN_DELETE: begin
            if (stat.cur_valid && stat.tag_eq) begin
              cmd.clr_slot   = 1'b1;
              cmd.set_res    = 1'b1;
              cmd.res_status = art_pkg::ST_OK;
              state_nxt      = S_RESP;
            end else if (stat.last) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = art_pkg::ST_NOTFOUND;
              state_nxt      = S_RESP;
            end else begin
              cmd.step = 1'b1;
            end
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = art_pkg::ST_NOTFOUND;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_RESP: begin
        // output register free or being drained this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/art_dpath.sv
// region table datapath: slot storage, range comparator, result registers
// depends on art_pkg
`default_nettype none

module art_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire art_pkg::func_t     in_func,
  input  wire art_pkg::addr_t     in_lookup_addr,
  input  wire art_pkg::addr_t     in_range_start,
  input  wire art_pkg::addr_t     in_range_end,
  input  wire art_pkg::tag_t      in_region_tag,
  input  wire art_pkg::art_cmd_t  cmd,
  output art_pkg::art_stat_t      stat,
  output logic                    out_hit,
  output art_pkg::tag_t           out_hit_tag,
  output art_pkg::status_t        out_status
);

  localparam art_pkg::slot_idx_t LastIdx = art_pkg::SLOT_BITS'(art_pkg::REGION_COUNT - 1);

  // slot storage, valid bits cleared at reset
  logic [art_pkg::REGION_COUNT-1:0] slot_valid_r;
  art_pkg::addr_t                   slot_start_r [art_pkg::REGION_COUNT];
  art_pkg::addr_t                   slot_end_r   [art_pkg::REGION_COUNT];
  art_pkg::tag_t                    slot_tag_r   [art_pkg::REGION_COUNT];

  // captured item
  art_pkg::func_t     func_r;
  art_pkg::addr_t     addr_r;
  art_pkg::addr_t     rs_r;
  art_pkg::addr_t     re_r;
  art_pkg::tag_t      tag_r;

  // scan state
  art_pkg::slot_idx_t idx_r;
  logic               free_found_r;
  art_pkg::slot_idx_t free_idx_r;

  // result and output registers
  logic               res_hit_r;
  art_pkg::tag_t      res_tag_r;
  art_pkg::status_t   res_status_r;
  logic               out_hit_r;
  art_pkg::tag_t      out_tag_r;
  art_pkg::status_t   out_status_r;

  art_pkg::addr_t     cur_start;
  art_pkg::addr_t     cur_end;
  art_pkg::tag_t      cur_tag;
  art_pkg::slot_idx_t wr_idx;

  assign cur_start = slot_start_r[idx_r];
  assign cur_end   = slot_end_r[idx_r];
  assign cur_tag   = slot_tag_r[idx_r];
  assign wr_idx    = free_found_r ? free_idx_r : idx_r;

  always_comb begin
    stat.func      = func_r;
    stat.cur_valid = slot_valid_r[idx_r];
    stat.contain   = (cur_start <= addr_r) && (addr_r < cur_end);
    stat.overlap   = !((re_r <= cur_start) || (cur_end <= rs_r));
    stat.tag_eq    = (cur_tag == tag_r);
    stat.last      = (idx_r == LastIdx);
    stat.free_seen = free_found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.wr_slot) begin
      slot_valid_r[wr_idx] <= 1'b1;
    end else if (cmd.clr_slot) begin
      slot_valid_r[idx_r] <= 1'b0;
    end
  end

  // entry payload is only read behind its valid bit
  always_ff @(posedge clk) begin
    if (cmd.wr_slot) begin
      slot_start_r[wr_idx] <= rs_r;
      slot_end_r[wr_idx]   <= re_r;
      slot_tag_r[wr_idx]   <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      addr_r <= in_lookup_addr;
      rs_r   <= in_range_start;
      re_r   <= in_range_end;
      tag_r  <= in_region_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else if (cmd.load) begin
      idx_r        <= '0;
      free_found_r <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_r + art_pkg::SLOT_BITS'(1);
      if (cmd.note_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_hit_r    <= cmd.res_hit;
      res_tag_r    <= cmd.res_hit ? cur_tag : '0;
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_hit_r    <= res_hit_r;
      out_tag_r    <= res_tag_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_hit     = out_hit_r;
  assign out_hit_tag = out_tag_r;
  assign out_status  = out_status_r;

endmodule

`default_nettype wire

>>> rtl/address_region_table_top.sv
// top level of the address region table: sequencer plus datapath
// depends on art_pkg, art_ifs, art_ctrl, art_dpath
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          func, lookup_addr, range_start, range_end, region_tag
//   out_ch   out  valid/ready          hit, hit_tag, status
//
// an item goes from its in_ch transfer to a slot scan, in which the shared range
// comparator visits the slots in turn, then to the output register load; the
// next in_ch transfer is taken only after that load. inserts visit every slot
// unless an overlap ends the scan, other ops stop at the first match. a result
// stalled on out_ch blocks only the handoff of the following result, not its
// transfer. reset (rst_n low, synchronous) empties the table at once.
`default_nettype none

module address_region_table_top (
  input  wire logic clk,
  input  wire logic rst_n,
  art_in_if.sink    in_ch,
  art_out_if.source out_ch
);

  art_pkg::art_cmd_t  cmd;
  art_pkg::art_stat_t stat;

  art_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  art_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_ch.func),
    .in_lookup_addr (in_ch.lookup_addr),
    .in_range_start (in_ch.range_start),
    .in_range_end   (in_ch.range_end),
    .in_region_tag  (in_ch.region_tag),
    .cmd            (cmd),
    .stat           (stat),
    .out_hit        (out_ch.hit),
    .out_hit_tag    (out_ch.hit_tag),
    .out_status     (out_ch.status)
  );

endmodule

`default_nettype wire

>>> rtl/art_checker.sv
// port-level checks for the address region table, bound to the top level
// depends on art_pkg and address_region_table_top_defines.svh
`default_nettype none

`include "address_region_table_top_defines.svh"

module art_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_hit,
  input wire art_pkg::tag_t    out_hit_tag,
  input wire art_pkg::status_t out_status
);

  // a result that is not taken stays offered
  `ART_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // only one item in work at a time
  `ART_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "transfer taken while busy")

  // a hit always reports success
  `ART_ASSERT_NOW(a_hit_ok, out_valid && out_hit, out_status == art_pkg::ST_OK, "hit without ok")

  // no tag is shown without a hit
  `ART_ASSERT_NOW(a_miss_tag, out_valid && !out_hit, out_hit_tag == '0, "tag on a miss")

endmodule

bind address_region_table_top art_checker u_art_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_hit     (out_ch.hit),
  .out_hit_tag (out_ch.hit_tag),
  .out_status  (out_ch.status)
);

`default_nettype wire
